/* src/wrps_pkg.sv */
// Package for the weighted random peer selector.
// Types, codes and sizing constants shared by the top level and the modulo unit.
`timescale 1ns / 1ps
package wrps_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned PEER_BITS   = 6;
  localparam int unsigned CNT_BITS    = 7;
  localparam int unsigned WEIGHT_BITS = 8;
  localparam int unsigned SUM_BITS    = 14;
  localparam int unsigned CONN_BITS   = 16;
  localparam int unsigned RND_BITS    = 31;
  localparam int unsigned RETRY_BITS  = 8;
  localparam int unsigned PROD_BITS   = CONN_BITS + WEIGHT_BITS;
  localparam int unsigned STEP_BITS   = $clog2(RND_BITS);

  localparam logic [SUM_BITS-1:0]   TOTAL_MAX   = '1;
  localparam logic [CONN_BITS-1:0]  CONN_MAX    = '1;
  localparam logic [RETRY_BITS-1:0] RETRY_MAX   = '1;
  localparam logic [RETRY_BITS-1:0] RETRY_RESET = 8'd20;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_STATUS  = 2'd1,
    CMD_SESSION = 2'd2,
    CMD_DRAW    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RES_ACK      = 2'd0,
    RES_AGAIN    = 2'd1,
    RES_SELECTED = 2'd2,
    RES_FALLBACK = 2'd3
  } res_e;

  typedef enum logic [1:0] {
    CFG_TWO_CHOICE  = 2'd0,
    CFG_PEER_COUNT  = 2'd1,
    CFG_RETRY_LIMIT = 2'd2,
    CFG_NONE        = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_SREAD,
    ST_SCMP,
    ST_CREAD,
    ST_CHECK,
    ST_FREAD,
    ST_MUL,
    ST_CMP
  } state_e;

  typedef struct packed {
    cmd_e                   command;
    logic [PEER_BITS-1:0]   peer_index;
    logic [WEIGHT_BITS-1:0] peer_weight;
    logic [CONN_BITS-1:0]   conn_count;
    logic                   available;
    logic [RND_BITS-1:0]    random_word;
  } in_t;

  typedef struct packed {
    res_e                 status;
    logic [PEER_BITS-1:0] chosen_peer;
  } out_t;

endpackage

/* src/wrps_mod.sv */
// Restoring remainder unit: random word modulo total weight, one bit per cycle.
// Depends on wrps_pkg.
`timescale 1ns / 1ps
module wrps_mod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wrps_pkg::RND_BITS-1:0]  dividend_i,
  input  logic [wrps_pkg::SUM_BITS-1:0]  divisor_i,
  output logic                           done_o,
  output logic [wrps_pkg::SUM_BITS-1:0]  rem_o
);
  import wrps_pkg::*;

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(RND_BITS - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_BITS-1:0]  cnt_q, cnt_d;
  logic [RND_BITS-1:0]   dvd_q, dvd_d;
  logic [SUM_BITS-1:0]   rem_q, rem_d;
  logic [SUM_BITS-1:0]   dsr_q, dsr_d;
  logic [SUM_BITS:0]     trial;

  assign trial = {rem_q, dvd_q[RND_BITS-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[RND_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = SUM_BITS'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[SUM_BITS-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("modulo done while busy");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("modulo restarted while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("modulo done held");

endmodule

/* src/weighted_random_peer_selector.sv */
// Weighted random peer selector: top level, command sequencer and peer tables.
// Depends on wrps_pkg and wrps_mod.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+----------------------
//  in       | input     | in_valid_i / in_stall_o     | in_item_i  (in_t)
//  out      | output    | out_valid_o / out_stall_i   | out_item_o (out_t)
//  cfg      | input     | cfg_we_i                    | cfg_idx_i, cfg_data_i
//
// Load, status, session and immediate fallback items: result at the next edge.
// Other draws: the bit-serial modulo unit, then one to six binary search steps
// (each a table read and a compare), then candidate read and check; a second
// two-choice candidate adds a read of the first, a multiply and a compare.
// Reset is asynchronous; the status table reads as zero until written.
// A waiting result stalls the input, and a draw holds its final step until then.
`timescale 1ns / 1ps
module weighted_random_peer_selector (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wrps_pkg::in_t      in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wrps_pkg::out_t     out_item_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i
);
  import wrps_pkg::*;

  localparam int unsigned RNG_W  = SUM_BITS + WEIGHT_BITS;
  localparam int unsigned STAT_W = 1 + CONN_BITS;

  state_e                 state_q, state_d;
  logic                   two_q;
  logic [CNT_BITS-1:0]    pc_q;
  logic [RETRY_BITS-1:0]  lim_q;
  logic [SUM_BITS-1:0]    total_q, total_d;
  logic [TABLE_DEPTH-1:0] tried_q, tried_d;
  logic [RETRY_BITS-1:0]  retry_q, retry_d;
  logic                   fcv_q, fcv_d;
  logic [PEER_BITS-1:0]   first_q, first_d;
  logic [SUM_BITS-1:0]    x_q, x_d;
  logic [CNT_BITS-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [PEER_BITS-1:0]   rd_addr_q, rd_addr_d;
  logic [PEER_BITS-1:0]   cand_q, cand_d;
  logic [CONN_BITS-1:0]   conn_c_q, conn_c_d, conn_f_q, conn_f_d;
  logic [WEIGHT_BITS-1:0] w_c_q, w_c_d;
  logic                   avail_f_q, avail_f_d;
  logic [PROD_BITS-1:0]   prod_c_q, prod_c_d, prod_f_q, prod_f_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;

  logic [RNG_W-1:0]       rng_mem [TABLE_DEPTH];
  logic [STAT_W-1:0]      stat_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] stat_vld_q, stat_vld_d;
  logic [RNG_W-1:0]       rd_rng_q;
  logic [STAT_W-1:0]      rd_stat_q;

  logic                   rng_we, stat_we;
  logic [PEER_BITS-1:0]   rng_wa, stat_wa;
  logic [RNG_W-1:0]       rng_wd;
  logic [STAT_W-1:0]      stat_wd;

  logic                   fin_ok, in_acc, draw_fb, srch_more, chk_pair, mod_start, mod_done;
  logic [SUM_BITS-1:0]    mod_rem;
  logic [CNT_BITS-1:0]    n_eff, nlo, nhi;
  logic [SUM_BITS-1:0]    rd_start;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic                   rd_avail;
  logic [CONN_BITS-1:0]   rd_conn;
  logic                   rej;
  logic                   do_sel, do_fail, fail_keep;
  logic [PEER_BITS-1:0]   sel_peer;
  logic [CONN_BITS-1:0]   sel_conn;
  logic                   sel_avail;
  logic [RETRY_BITS-1:0]  retry_inc;
  logic [SUM_BITS-1:0]    load_base;
  logic [SUM_BITS:0]      load_sum;

  assign fin_ok     = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !fin_ok;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign n_eff    = (pc_q > CNT_BITS'(TABLE_DEPTH)) ? CNT_BITS'(TABLE_DEPTH) : pc_q;
  assign draw_fb  = (n_eff <= CNT_BITS'(1)) || (retry_q > lim_q) || (total_q == '0);
  assign rd_start = rd_rng_q[RNG_W-1:WEIGHT_BITS];
  assign rd_w     = rd_rng_q[WEIGHT_BITS-1:0];
  assign rd_avail = rd_stat_q[STAT_W-1];
  assign rd_conn  = rd_stat_q[CONN_BITS-1:0];

  assign nlo       = (x_q < rd_start) ? lo_q : {1'b0, rd_addr_q};
  assign nhi       = (x_q < rd_start) ? {1'b0, rd_addr_q} : hi_q;
  assign srch_more = (nhi - nlo) > CNT_BITS'(1);

  assign rej       = (two_q && fcv_q && cand_q == first_q) || tried_q[cand_q] || !rd_avail;
  assign chk_pair  = !rej && two_q && fcv_q;
  assign retry_inc = (retry_q == RETRY_MAX) ? RETRY_MAX : retry_q + 1'b1;

  assign load_base = (in_item_i.peer_index == '0) ? '0 : total_q;
  assign load_sum  = {1'b0, load_base} + (SUM_BITS+1)'(in_item_i.peer_weight);

  assign mod_start = (state_q == ST_IDLE) && in_acc && in_item_i.command == CMD_DRAW
                     && !draw_fb;

  wrps_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (in_item_i.random_word),
    .divisor_i  (total_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (mod_start) state_d = ST_MOD;
      ST_MOD:   if (mod_done) state_d = ST_SREAD;
      ST_SREAD: state_d = ST_SCMP;
      ST_SCMP:  state_d = srch_more ? ST_SREAD : ST_CREAD;
      ST_CREAD: state_d = ST_CHECK;
      ST_CHECK: if (fin_ok) state_d = chk_pair ? ST_FREAD : ST_IDLE;
      ST_FREAD: state_d = ST_MUL;
      ST_MUL:   state_d = ST_CMP;
      ST_CMP:   if (fin_ok) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    total_d    = total_q;
    tried_d    = tried_q;
    retry_d    = retry_q;
    fcv_d      = fcv_q;
    first_d    = first_q;
    x_d        = x_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    rd_addr_d  = rd_addr_q;
    cand_d     = cand_q;
    conn_c_d   = conn_c_q;
    w_c_d      = w_c_q;
    conn_f_d   = conn_f_q;
    avail_f_d  = avail_f_q;
    prod_c_d   = prod_c_q;
    prod_f_d   = prod_f_q;
    stat_vld_d = stat_vld_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d      = out_q;
    rng_we     = 1'b0;
    rng_wa     = in_item_i.peer_index;
    rng_wd     = {load_base, in_item_i.peer_weight};
    stat_we    = 1'b0;
    stat_wa    = in_item_i.peer_index;
    stat_wd    = {in_item_i.available, in_item_i.conn_count};
    do_sel     = 1'b0;
    do_fail    = 1'b0;
    fail_keep  = 1'b0;
    sel_peer   = cand_q;
    sel_conn   = rd_conn;
    sel_avail  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_item_i.command)
            CMD_LOAD: begin
              rng_we  = 1'b1;
              total_d = load_sum[SUM_BITS] ? TOTAL_MAX : load_sum[SUM_BITS-1:0];
              out_valid_d = 1'b1;
              out_d   = '{status: RES_ACK, chosen_peer: '0};
            end
            CMD_STATUS: begin
              stat_we = 1'b1;
              stat_vld_d[in_item_i.peer_index] = 1'b1;
              out_valid_d = 1'b1;
              out_d   = '{status: RES_ACK, chosen_peer: '0};
            end
            CMD_SESSION: begin
              tried_d = '0;
              retry_d = '0;
              fcv_d   = 1'b0;
              first_d = '0;
              out_valid_d = 1'b1;
              out_d   = '{status: RES_ACK, chosen_peer: '0};
            end
            CMD_DRAW: begin
              if (draw_fb) begin
                fcv_d = 1'b0;
                out_valid_d = 1'b1;
                out_d = '{status: RES_FALLBACK, chosen_peer: '0};
              end
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          x_d       = mod_rem;
          lo_d      = '0;
          hi_d      = n_eff;
          rd_addr_d = PEER_BITS'(n_eff >> 1);
        end
      end
      ST_SCMP: begin
        lo_d = nlo;
        hi_d = nhi;
        if (srch_more) begin
          rd_addr_d = PEER_BITS'(({1'b0, nlo} + {1'b0, nhi}) >> 1);
        end else begin
          cand_d    = nlo[PEER_BITS-1:0];
          rd_addr_d = nlo[PEER_BITS-1:0];
        end
      end
      ST_CHECK: begin
        if (fin_ok) begin
          if (rej) begin
            do_fail = 1'b1;
          end else if (two_q && !fcv_q) begin
            do_fail   = 1'b1;
            fail_keep = 1'b1;
          end else if (two_q) begin
            conn_c_d  = rd_conn;
            w_c_d     = rd_w;
            rd_addr_d = first_q;
          end else begin
            do_sel = 1'b1;
          end
        end
      end
      ST_MUL: begin
        prod_c_d  = PROD_BITS'(conn_c_q) * PROD_BITS'(rd_w);
        prod_f_d  = PROD_BITS'(rd_conn) * PROD_BITS'(w_c_q);
        conn_f_d  = rd_conn;
        avail_f_d = rd_avail;
      end
      ST_CMP: begin
        if (fin_ok) begin
          do_sel = 1'b1;
          if (prod_c_q > prod_f_q) begin
            sel_peer  = first_q;
            sel_conn  = conn_f_q;
            sel_avail = avail_f_q;
          end else begin
            sel_conn  = conn_c_q;
          end
        end
      end
      default: ;
    endcase

    if (do_fail) begin
      retry_d = retry_inc;
      if (fail_keep) begin
        fcv_d   = 1'b1;
        first_d = cand_q;
      end
      out_valid_d = 1'b1;
      if (retry_inc > lim_q) begin
        fcv_d = 1'b0;
        out_d = '{status: RES_FALLBACK, chosen_peer: '0};
      end else begin
        out_d = '{status: RES_AGAIN, chosen_peer: '0};
      end
    end

    if (do_sel) begin
      stat_we = 1'b1;
      stat_wa = sel_peer;
      stat_wd = {sel_avail, (sel_conn == CONN_MAX) ? CONN_MAX : sel_conn + 1'b1};
      stat_vld_d[sel_peer] = 1'b1;
      tried_d[sel_peer]    = 1'b1;
      fcv_d       = 1'b0;
      out_valid_d = 1'b1;
      out_d       = '{status: RES_SELECTED, chosen_peer: sel_peer};
    end
  end

  // tables: no write falls in a cycle whose read is used, so no forwarding
  always_ff @(posedge clk_i) begin
    if (rng_we) rng_mem[rng_wa] <= rng_wd;
    rd_rng_q <= rng_mem[rd_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (stat_we) stat_mem[stat_wa] <= stat_wd;
    rd_stat_q <= stat_vld_q[rd_addr_q] ? stat_mem[rd_addr_q] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      two_q       <= 1'b0;
      pc_q        <= CNT_BITS'(1);
      lim_q       <= RETRY_RESET;
      total_q     <= '0;
      tried_q     <= '0;
      retry_q     <= '0;
      fcv_q       <= 1'b0;
      first_q     <= '0;
      stat_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      tried_q     <= tried_d;
      retry_q     <= retry_d;
      fcv_q       <= fcv_d;
      first_q     <= first_d;
      stat_vld_q  <= stat_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_TWO_CHOICE:  two_q <= cfg_data_i[0];
          CFG_PEER_COUNT:  pc_q  <= cfg_data_i[CNT_BITS-1:0];
          CFG_RETRY_LIMIT: lim_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_d_reg: begin
      x_q       <= x_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      rd_addr_q <= rd_addr_d;
      cand_q    <= cand_d;
      conn_c_q  <= conn_c_d;
      w_c_q     <= w_c_d;
      conn_f_q  <= conn_f_d;
      avail_f_q <= avail_f_d;
      prod_c_q  <= prod_c_d;
      prod_f_q  <= prod_f_d;
      out_q     <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_sel_tried: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == RES_SELECTED |-> tried_q[out_q.chosen_peer])
    else $error("selected peer not marked tried");
  a_mod_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == ST_MOD) else $error("modulo result outside draw");
  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCMP |-> hi_q > lo_q) else $error("search window empty");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_we |-> state_q == ST_IDLE || state_q == ST_CHECK || state_q == ST_CMP)
    else $error("status write outside its slots");

endmodule

/* verif/wrps_checker.sv */
// Checker for the weighted random peer selector: watches the item and config ports,
// predicts each result and compares it with what the block returns.
// Depends on wrps_pkg.
`timescale 1ns / 1ps
module wrps_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  wrps_pkg::in_t  in_item_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  wrps_pkg::out_t out_item_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [7:0]     cfg_data_i,
  output int             errors_o,
  output int             pending_o,
  output int             selected_o,
  output int             fallbacks_o
);
  import wrps_pkg::*;

  logic [SUM_BITS-1:0]    starts [TABLE_DEPTH];
  logic [WEIGHT_BITS-1:0] weights [TABLE_DEPTH];
  logic [CONN_BITS-1:0]   conns [TABLE_DEPTH];
  logic                   usable [TABLE_DEPTH];
  logic [SUM_BITS-1:0]    total;
  logic [63:0]            tried;
  logic [RETRY_BITS-1:0]  retries;
  logic                   first_valid;
  logic [PEER_BITS-1:0]   first_peer;
  logic                   two_choice;
  logic [CNT_BITS-1:0]    peers_used;
  logic [RETRY_BITS-1:0]  retry_lim;

  out_t expected_results[$];

  assign pending_o = expected_results.size();

  task automatic report(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  task automatic count_miss(output out_t r);
    if (retries != RETRY_MAX) retries++;
    r.chosen_peer = '0;
    if (retries > retry_lim) begin
      first_valid = 1'b0;
      r.status = RES_FALLBACK;
    end else begin
      r.status = RES_AGAIN;
    end
  endtask

  task automatic predict_pick(input in_t it, output out_t r);
    int unsigned n, x, lo, hi, mid, sum, lhs, rhs;
    logic [PEER_BITS-1:0] cand, sel;
    r.status = RES_ACK;
    r.chosen_peer = '0;
    case (it.command)
      CMD_LOAD: begin
        if (it.peer_index == 0) total = '0;
        starts[it.peer_index] = total;
        weights[it.peer_index] = it.peer_weight;
        sum = total + it.peer_weight;
        total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[SUM_BITS-1:0];
      end
      CMD_STATUS: begin
        conns[it.peer_index] = it.conn_count;
        usable[it.peer_index] = it.available;
      end
      CMD_SESSION: begin
        tried = '0;
        retries = '0;
        first_valid = 1'b0;
        first_peer = '0;
      end
      default: begin
        n = (peers_used > TABLE_DEPTH) ? TABLE_DEPTH : peers_used;
        if (n <= 1 || retries > retry_lim || total == 0) begin
          first_valid = 1'b0;
          r.status = RES_FALLBACK;
        end else begin
          x = it.random_word % total;
          lo = 0;
          hi = n;
          while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (x < starts[mid]) hi = mid;
            else lo = mid;
          end
          cand = lo[PEER_BITS-1:0];
          if ((two_choice && first_valid && cand == first_peer) || tried[cand] || !usable[cand])
          begin
            count_miss(r);
          end else if (two_choice && !first_valid) begin
            first_valid = 1'b1;
            first_peer = cand;
            count_miss(r);
          end else begin
            sel = cand;
            if (two_choice) begin
              lhs = conns[cand] * weights[first_peer];
              rhs = conns[first_peer] * weights[cand];
              if (lhs > rhs) sel = first_peer;
            end
            first_valid = 1'b0;
            tried[sel] = 1'b1;
            if (conns[sel] != CONN_MAX) conns[sel]++;
            r.status = RES_SELECTED;
            r.chosen_peer = sel;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t r, got;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        starts[i] = '0;
        weights[i] = '0;
        conns[i] = '0;
        usable[i] = 1'b0;
      end
      total = '0;
      tried = '0;
      retries = '0;
      first_valid = 1'b0;
      first_peer = '0;
      two_choice = 1'b0;
      peers_used = 7'd1;
      retry_lim = RETRY_RESET;
      expected_results.delete();
      errors_o = 0;
      selected_o = 0;
      fallbacks_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TWO_CHOICE:  two_choice = cfg_data_i[0];
          CFG_PEER_COUNT:  peers_used = cfg_data_i[CNT_BITS-1:0];
          CFG_RETRY_LIMIT: retry_lim = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got = out_item_i;
        if (expected_results.size() == 0) begin
          report("unexpected result", got, -1);
        end else begin
          r = expected_results.pop_front();
          if (got.status != r.status) report("status", got.status, r.status);
          if (got.chosen_peer != r.chosen_peer) report("chosen_peer", got.chosen_peer, r.chosen_peer);
          if (r.status == RES_SELECTED) selected_o++;
          if (r.status == RES_FALLBACK) fallbacks_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_pick(in_item_i, r);
        expected_results.push_back(r);
      end
    end
  end
endmodule

/* verif/tb.sv */
// Testbench top for the weighted random peer selector: clock, reset, item and
// config stimulus, receiver stalls and the final verdict. Depends on wrps_pkg,
// wrps_checker and the block itself.
`timescale 1ns / 1ps
module tb;
  import wrps_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_NONE;
  logic [7:0] cfg_data = '0;

  int errors, pending, selected, fallbacks;
  int items_sent = 0;
  int settings = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  weighted_random_peer_selector dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  wrps_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .selected_o(selected), .fallbacks_o(fallbacks)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls (none while calm), one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold == 0) begin
        hold = 400;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  task automatic send_item(input in_t it);
    if (!calm) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  function automatic in_t make_item(input cmd_e cmd, input int idx);
    in_t it;
    it.command = cmd;
    it.peer_index = idx[PEER_BITS-1:0];
    it.peer_weight = 8'($urandom_range(0, 255));
    it.conn_count = ($urandom_range(3) == 0) ? 16'($urandom_range(65530, 65535))
                                             : 16'($urandom_range(0, 65535));
    it.available = ($urandom_range(4) != 0);
    it.random_word = 31'($urandom);
    return it;
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_e idx, input int value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[7:0];
    @(posedge clk);
  endtask

  task automatic set_regs(input int tc, input int cnt, input int lim);
    write_reg(CFG_TWO_CHOICE, tc);
    write_reg(CFG_PEER_COUNT, cnt);
    write_reg(CFG_RETRY_LIMIT, lim);
    cfg_we <= 1'b0;
    cfg_idx <= CFG_NONE;
    @(posedge clk);
    settings++;
  endtask

  task automatic load_table();
    in_t it;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      it = make_item(CMD_LOAD, i);
      if (i == 5) it.peer_weight = 8'd0;
      if (i == 6) it.peer_weight = 8'd255;
      send_item(it);
    end
  endtask

  initial begin
    in_t it;
    int phase_tc[7] = '{0, 1, 1, 0, 1, 0, 1};
    int phase_cnt[7] = '{64, 64, 2, 1, 127, 17, 40};
    int phase_lim[7] = '{20, 255, 0, 5, 3, 255, 0};
    int ndraw;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero total weight: draw falls back without touching the table
    set_regs(1, 64, 20);
    it = make_item(CMD_DRAW, 0);
    send_item(it);
    load_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      it = make_item(CMD_STATUS, i);
      it.available = 1'b1;
      it.conn_count = (i == 3) ? 16'hFFFF : 16'd0;
      send_item(it);
    end
    // directed: extremes of the fields
    it = make_item(CMD_SESSION, 63);
    it.peer_weight = 8'hFF;
    it.conn_count = 16'hFFFF;
    it.random_word = '1;
    send_item(it);
    for (int i = 0; i < 12; i++) begin
      it = make_item(CMD_DRAW, i);
      it.random_word = (i == 0) ? '0 : (i == 1) ? '1 : 31'($urandom);
      send_item(it);
    end
    it = make_item(CMD_LOAD, 63);
    it.peer_weight = 8'hFF;
    send_item(it);
    settle();

    for (int p = 0; p < 7; p++) begin
      set_regs(phase_tc[p], phase_cnt[p], phase_lim[p]);
      calm = (p == 1);
      if (p == 2) hold_req = 1'b1;
      if (p == 4) load_table();
      repeat (12) begin
        if ($urandom_range(9) < 7) begin
          send_item(make_item(CMD_SESSION, 0));
          repeat ($urandom_range(0, 2)) send_item(make_item(CMD_STATUS, $urandom_range(0, 63)));
          ndraw = $urandom_range(1, 8);
          repeat (ndraw) send_item(make_item(CMD_DRAW, $urandom_range(0, 63)));
        end else begin
          repeat ($urandom_range(1, 3)) begin
            it = make_item(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 63));
            if (it.command == CMD_LOAD && it.peer_index == 0) it.peer_index = 6'd1;
            send_item(it);
          end
        end
      end
      settle();
    end

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d items over %0d register settings; %0d selections, %0d fallbacks.",
             items_sent, settings, selected, fallbacks);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

/* files.f */
src/wrps_pkg.sv
src/wrps_mod.sv
src/weighted_random_peer_selector.sv
verif/wrps_checker.sv
verif/tb.sv
